// ===== sv/spg_pkg.sv =====
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types, constants and helpers for the setpoint profile generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  // Table size and tick rate
  localparam int MAX_POINTS       = 16;
  localparam int TICKS_PER_SECOND = 5;
  localparam int IDX_W            = $clog2(MAX_POINTS);
  localparam int CNT_W            = $clog2(MAX_POINTS + 1);
  localparam int STEPS_W          = 20;

  // Slope divider: 33-bit magnitude dividend, divisor dt * ticks
  localparam int DIV_ITERS = 33;
  localparam int DIVR_W    = $clog2(65536 * TICKS_PER_SECOND);
  localparam int DIVCNT_W  = $clog2(DIV_ITERS + 1);

  // Stream widths
  localparam int S_TDATA_W = 88;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 32;
  localparam int M_TUSER_W = 4;

  // Item kinds
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_TICK  = 3'd0;
  localparam mode_t MODE_ADD   = 3'd1;
  localparam mode_t MODE_START = 3'd2;
  localparam mode_t MODE_STOP  = 3'd3;
  localparam mode_t MODE_CLEAR = 3'd4;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_TIME = 2'd1;
  localparam status_t ST_FULL = 2'd2;
  localparam status_t ST_IDLE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic tick_idle;
    logic tick_end;
    logic rd_next;
    logic advance;
    logic hold;
    logic hold_level;
    logic add;
    logic start;
    logic stop;
    logic clear;
    logic div_start;
    logic div_step;
    logic div_finish;
    logic mul;
    logic sum;
    logic push;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    mode_t mode;
    logic  running;
    logic  has_next;
    logic  due;
    logic  nx_ramp;
    logic  div_ok;
    logic  div_done;
    logic  out_free;
  } stat_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [53:0] x);
    logic signed [53:0] hi;
    logic signed [53:0] lo;
    hi = 54'sh7FFF_FFFF;
    lo = -54'sh8000_0000;
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== sv/spg_ctrl.sv =====
// ----------------------------------------------------------------------------
// spg_ctrl
// Sequencer: decodes each item and steps the datapath through table reads,
// the slope division, the ramp multiply and the result hand-off.
// ----------------------------------------------------------------------------
module spg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  spg_pkg::stat_t stat,
  output spg_pkg::cmd_t  cmd
);
  import spg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TWAIT, S_LOAD, S_LWAIT, S_DIV, S_MUL, S_ADD, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  // Command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.mode)
          MODE_TICK: begin
            if (!stat.running) begin
              cmd.tick_idle = 1'b1;
              state_next    = S_OUT;
            end else if (!stat.has_next) begin
              cmd.tick_end = 1'b1;
              state_next   = S_OUT;
            end else begin
              cmd.rd_next = 1'b1;
              state_next  = S_TWAIT;
            end
          end
          MODE_ADD: begin
            cmd.add    = 1'b1;
            state_next = S_OUT;
          end
          MODE_START: begin
            cmd.start  = 1'b1;
            state_next = S_LOAD;
          end
          MODE_STOP: begin
            cmd.stop   = 1'b1;
            state_next = S_OUT;
          end
          MODE_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = S_OUT;
          end
          default: begin
            state_next = S_OUT;
          end
        endcase
      end
      S_TWAIT: begin
        if (stat.due) begin
          cmd.advance = 1'b1;
          state_next  = S_LOAD;
        end else begin
          cmd.hold = 1'b1;
          if (stat.nx_ramp) begin
            state_next = S_MUL;
          end else begin
            cmd.hold_level = 1'b1;
            state_next     = S_OUT;
          end
        end
      end
      S_LOAD: begin
        if (stat.has_next) begin
          cmd.rd_next = 1'b1;
          state_next  = S_LWAIT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_LWAIT: begin
        if (stat.div_ok) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.div_finish = 1'b1;
          state_next     = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/spg_datapath.sv =====
// ----------------------------------------------------------------------------
// spg_datapath
// Breakpoint table, curve state, bit-serial slope divider, ramp multiply and
// the output register.
// ----------------------------------------------------------------------------
module spg_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [spg_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic [spg_pkg::S_TUSER_W-1:0]    s_tuser,
  input  spg_pkg::cmd_t                    cmd,
  output spg_pkg::stat_t                   stat,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [spg_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [spg_pkg::M_TUSER_W-1:0]    m_tuser
);
  import spg_pkg::*;

  // Latched item
  mode_t              it_mode;
  logic [31:0]        it_now;
  logic [15:0]        it_ptime;
  logic signed [31:0] it_pval;
  logic               it_pramp;

  // Breakpoint table: {time, value, ramp}; entry 0 is the fixed origin
  logic [48:0]        mem [MAX_POINTS];
  logic [48:0]        rd_data;
  logic [CNT_W-1:0]   count;
  logic [15:0]        last_time;

  // Curve state
  logic               running;
  logic [31:0]        start_epoch;
  logic [IDX_W-1:0]   seg;
  logic signed [31:0] cur_value;
  logic [15:0]        cur_time;
  logic [STEPS_W-1:0] steps;
  logic signed [31:0] inc;

  // Result being built
  logic signed [31:0] res_level;
  logic               res_valid;
  logic               res_ended;
  status_t            res_status;

  // Divider and multiplier
  logic [DIVR_W-1:0]   div_rem;
  logic [32:0]         div_q;
  logic [DIVR_W-1:0]   div_d;
  logic                div_neg;
  logic [DIVCNT_W-1:0] div_cnt;
  logic signed [52:0]  prod;

  // Next-entry fields from the read port
  logic [15:0]        nx_time;
  logic signed [31:0] nx_value;
  logic               nx_ramp;
  logic [IDX_W-1:0]   nx_idx;
  logic               has_next;
  logic [32:0]        due_time;
  logic               due;
  logic signed [32:0] dv;
  logic [32:0]        dv_mag;
  logic [15:0]        dt;
  logic [DIVR_W-1:0]  divisor;
  logic [DIVR_W:0]    div_r2;
  logic               div_ge;
  logic signed [33:0] q_signed;
  logic signed [53:0] sum_wide;
  logic               out_free;

  assign nx_time  = rd_data[48:33];
  assign nx_value = rd_data[32:1];
  assign nx_ramp  = rd_data[0];
  assign nx_idx   = seg + 1'b1;
  assign has_next = (CNT_W'(seg) + 1'b1) < count;

  // Next point due once start + its offset is reached (no wrap)
  assign due_time = {1'b0, start_epoch} + 33'(nx_time);
  assign due      = {1'b0, it_now} >= due_time;

  // Slope operands
  assign dv      = {nx_value[31], nx_value} - {cur_value[31], cur_value};
  assign dv_mag  = dv[32] ? 33'(-dv) : 33'(dv);
  assign dt      = nx_time - cur_time;
  assign divisor = DIVR_W'(dt) * DIVR_W'(TICKS_PER_SECOND);

  // One restoring division step
  assign div_r2 = {div_rem, div_q[32]};
  assign div_ge = div_r2 >= {1'b0, div_d};

  assign q_signed = div_neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
  assign sum_wide = 54'(cur_value) + 54'(prod);

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    stat          = '0;
    stat.mode     = it_mode;
    stat.running  = running;
    stat.has_next = has_next;
    stat.due      = due;
    stat.nx_ramp  = nx_ramp;
    stat.div_ok   = nx_ramp && (nx_time > cur_time);
    stat.div_done = (div_cnt == '0);
    stat.out_free = out_free;
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.add && (it_ptime > last_time) && (count < CNT_W'(MAX_POINTS))) begin
      mem[count[IDX_W-1:0]] <= {it_ptime, it_pval, it_pramp};
    end
    if (cmd.rd_next) begin
      rd_data <= mem[nx_idx];
    end
  end

  // Item latch, result build, divider and multiplier payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_mode    <= s_tuser;
      it_now     <= s_tdata[31:0];
      it_ptime   <= s_tdata[47:32];
      it_pval    <= s_tdata[79:48];
      it_pramp   <= s_tdata[80];
      res_level  <= '0;
      res_valid  <= 1'b0;
      res_ended  <= 1'b0;
      res_status <= ST_OK;
    end
    if (cmd.tick_idle) begin
      res_status <= ST_IDLE;
    end
    if (cmd.tick_end) begin
      res_ended <= 1'b1;
    end
    if (cmd.add) begin
      if (it_ptime <= last_time) begin
        res_status <= ST_TIME;
      end else if (count >= CNT_W'(MAX_POINTS)) begin
        res_status <= ST_FULL;
      end
    end
    if (cmd.advance) begin
      res_level <= nx_value;
      res_valid <= 1'b1;
    end
    if (cmd.hold_level) begin
      res_level <= cur_value;
      res_valid <= 1'b1;
    end
    if (cmd.sum) begin
      res_level <= sat32(sum_wide);
      res_valid <= 1'b1;
    end
    if (cmd.div_start) begin
      div_q   <= dv_mag;
      div_rem <= '0;
      div_d   <= divisor;
      div_neg <= dv[32];
    end
    if (cmd.div_step) begin
      div_q   <= {div_q[31:0], div_ge};
      div_rem <= div_ge ? DIVR_W'(div_r2 - {1'b0, div_d}) : DIVR_W'(div_r2);
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, steps}) * inc;
    end
  end

  // Control and curve state
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= CNT_W'(1);
      last_time   <= '0;
      running     <= 1'b0;
      start_epoch <= '0;
      seg         <= '0;
      cur_value   <= '0;
      cur_time    <= '0;
      steps       <= '0;
      inc         <= '0;
      div_cnt     <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      // Append a breakpoint
      if (cmd.add && (it_ptime > last_time) && (count < CNT_W'(MAX_POINTS))) begin
        count     <= count + 1'b1;
        last_time <= it_ptime;
      end
      // Stop, end of curve or clear: back to the origin point
      if (cmd.stop || cmd.tick_end || cmd.clear) begin
        running     <= 1'b0;
        start_epoch <= '0;
        seg         <= '0;
        cur_value   <= '0;
        cur_time    <= '0;
      end
      if (cmd.clear) begin
        count     <= CNT_W'(1);
        last_time <= '0;
        steps     <= '0;
        inc       <= '0;
      end
      if (cmd.start) begin
        running     <= 1'b1;
        start_epoch <= it_now;
        seg         <= '0;
        cur_value   <= '0;
        cur_time    <= '0;
        steps       <= '0;
        inc         <= '0;
      end
      if (cmd.advance) begin
        seg       <= nx_idx;
        cur_value <= nx_value;
        cur_time  <= nx_time;
        steps     <= '0;
        inc       <= '0;
      end
      // Ramp step count saturates
      if (cmd.hold && nx_ramp && (steps != '1)) begin
        steps <= steps + 1'b1;
      end
      // Divider sequencing and slope result
      if (cmd.div_start) begin
        div_cnt <= DIVCNT_W'(DIV_ITERS);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.div_finish) begin
        inc <= sat32(54'(q_signed));
      end
      // Output register
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_tdata <= res_level;
      m_tuser <= {res_status, res_ended, res_valid};
    end
  end

endmodule

// ===== sv/setpoint_profile_generator_core.sv =====
// ----------------------------------------------------------------------------
// setpoint_profile_generator_core
// Piecewise linear setpoint profile generator with step and ramp segments.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. Items are handled one at a time: the
// next item is taken only once the last result has been pushed. A table
// edit, a stop, a clear, an idle tick or a curve end tick goes straight to
// the output; a tick that holds a step value first reads the next entry, and
// a tick inside a ramp also runs the multiply and the add. A start, or a
// tick that advances, reads the following entry when there is one. A start
// onto a ramp segment and a tick that moves onto a ramp segment also run the
// 33-step bit-serial divider that forms the slope dv / (dt * TICKS_PER_SECOND).
// A stalled output holds the result in the controller until the output is free.
// The next item is taken while a result still waits in the output register.
// Breakpoint reads go through one registered memory port, so each table
// lookup waits in a state of its own for the read data.
module setpoint_profile_generator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // time_now[31:0], point_time[47:32], point_value[79:48], point_ramp[80]
  input  logic [spg_pkg::S_TDATA_W-1:0] s_tdata,
  // mode[2:0]
  input  logic [spg_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // level[31:0]
  output logic [spg_pkg::M_TDATA_W-1:0] m_tdata,
  // level_valid[0], curve_ended[1], status[3:2]
  output logic [spg_pkg::M_TUSER_W-1:0] m_tuser
);
  import spg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spg_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== sv/spg_checker.sv =====
// ----------------------------------------------------------------------------
// spg_assertions
// Port-level checks on the result stream of the profile generator.
// ----------------------------------------------------------------------------
module spg_assertions (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [spg_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [spg_pkg::M_TUSER_W-1:0] m_tuser
);
  import spg_pkg::*;

  // A stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // No setpoint means a zero level
  a_zero_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("level nonzero without level_valid");

  // Curve end carries no setpoint and an ok status
  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tuser[3:2] == ST_OK)
    else $error("curve end with setpoint or error");

  // An error status carries neither a setpoint nor an end
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3:2] != ST_OK |-> !m_tuser[0] && !m_tuser[1])
    else $error("error status with setpoint or end");

endmodule

bind setpoint_profile_generator_core spg_assertions u_chk (.*);
